// ===== hw/rtl/pmm_pkg.sv =====
package pmm_pkg;

  // Default sample width of the four correlation inputs.
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Internal fixed-point widths. All samples are brought to Q4.28.
  localparam int Q_W        = 32;              // one sample in Q4.28
  localparam int MAG_W      = Q_W;             // magnitude of one sample
  localparam int PROD_W     = 2 * MAG_W;       // A, B, |C| and |A-B| in Q.56
  localparam int WIDE_W     = 2 * PROD_W;      // inner radicand in Q.112
  localparam int ROOT_W     = PROD_W;          // floor root of a wide radicand
  localparam int OUT_W      = 32;              // result fields, unsigned Q1.31

  // Step counts of the bit-serial units.
  localparam int MUL_NARROW_STEPS  = MAG_W;
  localparam int MUL_WIDE_STEPS    = PROD_W;
  localparam int SQRT_WIDE_STEPS   = ROOT_W;
  localparam int SQRT_NARROW_STEPS = 34;
  localparam int NARROW_RAD_W      = 2 * SQRT_NARROW_STEPS;  // outer radicands, Q.58
  localparam int MATCH_W           = SQRT_NARROW_STEPS;      // outer roots, Q5.29
  localparam int REM_W             = ROOT_W + 4;
  localparam int CNT_W             = $clog2(MUL_WIDE_STEPS + 1);

  // Command to one of the shared serial units.
  typedef struct packed {
    logic start;
    logic wide;
  } unit_cmd_t;

  // Twice the root, saturated to the 32-bit result range.
  function automatic logic [OUT_W-1:0] emit_match(input logic [MATCH_W-1:0] root);
    logic sat;
    sat = |root[MATCH_W-1:OUT_W-1];
    emit_match = sat ? {OUT_W{1'b1}} : {root[OUT_W-2:0], 1'b0};
  endfunction

endpackage

// ===== hw/rtl/pmm_in_if.sv =====
interface pmm_in_if #(
  parameter int SAMPLE_WIDTH = pmm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] corr_pp;
  logic signed [SAMPLE_WIDTH-1:0] corr_pc;
  logic signed [SAMPLE_WIDTH-1:0] corr_cp;
  logic signed [SAMPLE_WIDTH-1:0] corr_cc;
  logic                           last_lag;

  modport source (
    output valid, corr_pp, corr_pc, corr_cp, corr_cc, last_lag,
    input  ready
  );

  modport sink (
    input  valid, corr_pp, corr_pc, corr_cp, corr_cc, last_lag,
    output ready
  );
endinterface

// ===== hw/rtl/pmm_out_if.sv =====
interface pmm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] typical_match;
  logic [31:0] best_match;
  logic [31:0] minimax_match;

  modport source (
    output valid, typical_match, best_match, minimax_match,
    input  ready
  );

  modport sink (
    input  valid, typical_match, best_match, minimax_match,
    output ready
  );
endinterface

// ===== hw/rtl/pmm_mul.sv =====
module pmm_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pmm_pkg::unit_cmd_t            cmd,
  input  logic [pmm_pkg::PROD_W-1:0]    mcand,
  input  logic [pmm_pkg::PROD_W-1:0]    mplier,
  output logic                          done,
  output logic [pmm_pkg::WIDE_W-1:0]    prod
);
  import pmm_pkg::*;

  // Shift-and-add multiplier, one multiplier bit per cycle. The multiplier
  // sits in the low half of the accumulator and shifts out as the product
  // shifts in from the top.
  logic [WIDE_W-1:0] acc_r;
  logic [WIDE_W-1:0] acc_nxt;
  logic [PROD_W-1:0] mcand_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [PROD_W:0]   sum;

  assign sum     = {1'b0, acc_r[WIDE_W-1:PROD_W]} + (acc_r[0] ? {1'b0, mcand_r} : '0);
  assign acc_nxt = {sum, acc_r[PROD_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.wide ? CNT_W'(MUL_WIDE_STEPS) : CNT_W'(MUL_NARROW_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r   <= {{PROD_W{1'b0}}, mplier};
      mcand_r <= mcand;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hw/rtl/pmm_sqrt.sv =====
module pmm_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pmm_pkg::unit_cmd_t            cmd,
  input  logic [pmm_pkg::WIDE_W-1:0]    rad,
  output logic                          done,
  output logic [pmm_pkg::ROOT_W-1:0]    root
);
  import pmm_pkg::*;

  // Restoring digit-by-digit square root: two radicand bits in, one root
  // bit out per cycle. A narrow radicand is left-aligned so the same
  // datapath serves both sizes.
  logic [WIDE_W-1:0] rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  rem_nxt;
  logic              fits;

  assign rem_sh  = {rem_r[REM_W-3:0], rad_r[WIDE_W-1:WIDE_W-2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign fits    = rem_sh >= trial;
  assign rem_nxt = fits ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.wide ? CNT_W'(SQRT_WIDE_STEPS) : CNT_W'(SQRT_NARROW_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rad_r  <= cmd.wide ? rad
                         : {rad[NARROW_RAD_W-1:0], {(WIDE_W-NARROW_RAD_W){1'b0}}};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[WIDE_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== hw/rtl/polarisation_match_max.sv =====
// Polarisation match maximum.
// The input channel carries one lag per transfer: four signed correlation
// samples (plus/cross template against plus/cross signal) and a last_lag flag.
// For every lag the block forms A, B and C, takes the typical, best and
// minimax matches by nested floor square roots, and keeps a running maximum
// of each. The transfer flagged last_lag produces one result transfer with
// the three maxima halved (unsigned Q1.31, saturated); the maxima then clear.
// A new lag is taken only when the previous one is through and, after a last
// lag, only once the output register is free as well. Each lag runs
// eight bit-serial multiplications (six of 32 steps, two of 64) and four
// bit-serial square roots (one of 64 steps, three of 34) in sequence on a
// single shared multiplier and a single shared root unit; in_ch.ready is high
// again after the last root and the maximum update, and after a last lag once
// the result is loaded into the output register.
// The result sits in an output register, so a stalled receiver does not stop
// the next lags; only a second last lag waits for the register to drain.
// Reset (synchronous, active low) clears the maxima, drops the result valid
// and leaves the input ready.
module polarisation_match_max #(
  parameter int SAMPLE_WIDTH = pmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pmm_in_if.sink    in_ch,
  pmm_out_if.source out_ch
);
  import pmm_pkg::*;

  // One-hot sequencer: each operation state issues one command to a shared
  // unit and moves on when that unit reports done.
  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_PP   = 15'b000000000000010,  // pp^2
    S_PC   = 15'b000000000000100,  // A = pp^2 + pc^2
    S_CP   = 15'b000000000001000,  // cp^2
    S_CC   = 15'b000000000010000,  // B = cp^2 + cc^2
    S_X1   = 15'b000000000100000,  // |pp*cp|
    S_X2   = 15'b000000001000000,  // |pc*cc|, then |C| and |A-B|
    S_DD   = 15'b000000010000000,  // (A-B)^2 / 4
    S_CM   = 15'b000000100000000,  // + C^2
    S_RS   = 15'b000001000000000,  // S = sqrt(inner)
    S_RT   = 15'b000010000000000,  // sqrt(4A)
    S_RB   = 15'b000100000000000,  // sqrt(2(A+B) + 4S)
    S_RM   = 15'b001000000000000,  // sqrt(2(A+B) - 4S), clamped at zero
    S_UPD  = 15'b010000000000000,
    S_EMIT = 15'b100000000000000
  } state_t;

  state_t st_r, st_nxt;
  logic   go_r, go_nxt;

  // Samples brought to Q4.28 by an exact left shift or a flooring right
  // shift, then split into magnitude and sign.
  logic signed [SAMPLE_WIDTH-1:0]    raw  [4];
  logic signed [SAMPLE_WIDTH+Q_W-1:0] ext [4];
  logic [Q_W-1:0]                    q    [4];
  logic [MAG_W-1:0]                  mag_nxt [4];
  logic [MAG_W-1:0]                  mag_r   [4];
  logic                              sgn_r   [4];
  logic                              last_r;

  assign raw[0] = in_ch.corr_pp;
  assign raw[1] = in_ch.corr_pc;
  assign raw[2] = in_ch.corr_cp;
  assign raw[3] = in_ch.corr_cc;

  for (genvar g = 0; g < 4; g++) begin : g_samp
    assign ext[g]     = $signed({raw[g], {Q_W{1'b0}}}) >>> SAMPLE_WIDTH;
    assign q[g]       = ext[g][Q_W-1:0];
    assign mag_nxt[g] = q[g][Q_W-1] ? (~q[g] + MAG_W'(1)) : q[g];
  end

  // Per-lag working registers.
  logic [PROD_W-1:0]  a_r, b_r, m1_r, c_r, diff_r, s_r;
  logic [WIDE_W-1:0]  inner_r;
  logic [MATCH_W-1:0] typ_r, best_r, mm_r;
  logic [MATCH_W-1:0] max_typ_r, max_best_r, max_mm_r;

  // Result register.
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_typ_r, out_best_r, out_mm_r;
  logic               out_free;

  // Shared units.
  unit_cmd_t          mul_cmd, sqrt_cmd;
  logic [PROD_W-1:0]  mul_a, mul_b;
  logic [WIDE_W-1:0]  mul_prod;
  logic [PROD_W-1:0]  prod_short;
  logic               mul_done;
  logic [WIDE_W-1:0]  sqrt_rad;
  logic [ROOT_W-1:0]  sqrt_root;
  logic               sqrt_done;
  logic               is_mul, is_sqrt;

  assign is_mul  = (st_r == S_PP) || (st_r == S_PC) || (st_r == S_CP) || (st_r == S_CC) ||
                   (st_r == S_X1) || (st_r == S_X2) || (st_r == S_DD) || (st_r == S_CM);
  assign is_sqrt = (st_r == S_RS) || (st_r == S_RT) || (st_r == S_RB) || (st_r == S_RM);

  // A narrow product of two 32-bit magnitudes lands in the middle of the
  // accumulator after 32 steps.
  assign prod_short = mul_prod[WIDE_W-MAG_W-1:MAG_W];

  // Operand selection for the multiplier.
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    mul_cmd.start = is_mul && !go_r;
    mul_cmd.wide  = 1'b0;
    case (st_r)
      S_PP: begin
        mul_a = PROD_W'(mag_r[0]);
        mul_b = PROD_W'(mag_r[0]);
      end
      S_PC: begin
        mul_a = PROD_W'(mag_r[1]);
        mul_b = PROD_W'(mag_r[1]);
      end
      S_CP: begin
        mul_a = PROD_W'(mag_r[2]);
        mul_b = PROD_W'(mag_r[2]);
      end
      S_CC: begin
        mul_a = PROD_W'(mag_r[3]);
        mul_b = PROD_W'(mag_r[3]);
      end
      S_X1: begin
        mul_a = PROD_W'(mag_r[0]);
        mul_b = PROD_W'(mag_r[2]);
      end
      S_X2: begin
        mul_a = PROD_W'(mag_r[1]);
        mul_b = PROD_W'(mag_r[3]);
      end
      S_DD: begin
        mul_a        = diff_r;
        mul_b        = diff_r;
        mul_cmd.wide = 1'b1;
      end
      S_CM: begin
        mul_a        = c_r;
        mul_b        = c_r;
        mul_cmd.wide = 1'b1;
      end
      default: ;
    endcase
  end

  // Outer radicands in Q.58: 4A, 2(A+B) + 4S and 2(A+B) - 4S clamped at zero.
  logic [PROD_W:0]         ab_sum;
  logic [PROD_W+1:0]       sum2, s4;
  logic [NARROW_RAD_W-1:0] rad_typ, rad_best, rad_mm;

  assign ab_sum   = {1'b0, a_r} + {1'b0, b_r};
  assign sum2     = {ab_sum, 1'b0};
  assign s4       = {s_r, 2'b00};
  assign rad_typ  = {2'b00, a_r, 2'b00};
  assign rad_best = NARROW_RAD_W'(sum2) + NARROW_RAD_W'(s4);
  assign rad_mm   = (sum2 > s4) ? NARROW_RAD_W'(sum2 - s4) : '0;

  always_comb begin
    sqrt_rad       = '0;
    sqrt_cmd.start = is_sqrt && !go_r;
    sqrt_cmd.wide  = 1'b0;
    case (st_r)
      S_RS: begin
        sqrt_rad      = inner_r;
        sqrt_cmd.wide = 1'b1;
      end
      S_RT: sqrt_rad = WIDE_W'(rad_typ);
      S_RB: sqrt_rad = WIDE_W'(rad_best);
      S_RM: sqrt_rad = WIDE_W'(rad_mm);
      default: ;
    endcase
  end

  pmm_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (mul_cmd),
    .mcand  (mul_a),
    .mplier (mul_b),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  pmm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (sqrt_cmd),
    .rad   (sqrt_rad),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // |C| from the two cross products: their magnitudes add when the product
  // signs agree and subtract otherwise, which avoids any signed overflow.
  logic              c_same;
  logic [PROD_W-1:0] c_nxt, diff_nxt;

  assign c_same   = (sgn_r[0] ^ sgn_r[2]) == (sgn_r[1] ^ sgn_r[3]);
  assign c_nxt    = c_same ? (m1_r + prod_short)
                  : ((m1_r >= prod_short) ? (m1_r - prod_short) : (prod_short - m1_r));
  assign diff_nxt = (a_r >= b_r) ? (a_r - b_r) : (b_r - a_r);

  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    go_nxt = go_r;
    case (st_r)
      S_IDLE: if (in_ch.valid) st_nxt = S_PP;
      S_UPD:  st_nxt = last_r ? S_EMIT : S_IDLE;
      S_EMIT: if (out_free) st_nxt = S_IDLE;
      default: begin
        if (!go_r) begin
          go_nxt = 1'b1;
        end else if (mul_done || sqrt_done) begin
          go_nxt = 1'b0;
          case (st_r)
            S_PP:    st_nxt = S_PC;
            S_PC:    st_nxt = S_CP;
            S_CP:    st_nxt = S_CC;
            S_CC:    st_nxt = S_X1;
            S_X1:    st_nxt = S_X2;
            S_X2:    st_nxt = S_DD;
            S_DD:    st_nxt = S_CM;
            S_CM:    st_nxt = S_RS;
            S_RS:    st_nxt = S_RT;
            S_RT:    st_nxt = S_RB;
            S_RB:    st_nxt = S_RM;
            S_RM:    st_nxt = S_UPD;
            default: st_nxt = S_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      max_typ_r   <= '0;
      max_best_r  <= '0;
      max_mm_r    <= '0;
    end else begin
      st_r <= st_nxt;
      go_r <= go_nxt;
      // A new result may be loaded in the same cycle the old one transfers.
      if (st_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (st_r == S_UPD) begin
        if (typ_r > max_typ_r)   max_typ_r  <= typ_r;
        if (best_r > max_best_r) max_best_r <= best_r;
        if (mm_r > max_mm_r)     max_mm_r   <= mm_r;
      end
      // The maxima are read into the result register and cleared together.
      if (st_r == S_EMIT && out_free) begin
        max_typ_r   <= '0;
        max_best_r  <= '0;
        max_mm_r    <= '0;
      end
    end
  end

  // Datapath registers; these carry no reset.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      for (int i = 0; i < 4; i++) begin
        mag_r[i] <= mag_nxt[i];
        sgn_r[i] <= q[i][Q_W-1];
      end
      last_r <= in_ch.last_lag;
    end
    if (mul_done) begin
      case (st_r)
        S_PP: a_r  <= prod_short;
        S_PC: a_r  <= a_r + prod_short;
        S_CP: b_r  <= prod_short;
        S_CC: b_r  <= b_r + prod_short;
        S_X1: m1_r <= prod_short;
        S_X2: begin
          c_r    <= c_nxt;
          diff_r <= diff_nxt;
        end
        S_DD: inner_r <= {2'b00, mul_prod[WIDE_W-1:2]};
        S_CM: inner_r <= inner_r + mul_prod;
        default: ;
      endcase
    end
    if (sqrt_done) begin
      case (st_r)
        S_RS: s_r    <= sqrt_root;
        S_RT: typ_r  <= sqrt_root[MATCH_W-1:0];
        S_RB: best_r <= sqrt_root[MATCH_W-1:0];
        S_RM: mm_r   <= sqrt_root[MATCH_W-1:0];
        default: ;
      endcase
    end
    if (st_r == S_EMIT && out_free) begin
      out_typ_r  <= emit_match(max_typ_r);
      out_best_r <= emit_match(max_best_r);
      out_mm_r   <= emit_match(max_mm_r);
    end
  end

  assign in_ch.ready          = (st_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.typical_match = out_typ_r;
  assign out_ch.best_match    = out_best_r;
  assign out_ch.minimax_match = out_mm_r;

endmodule

// ===== sim/tb_polarisation_match_max.sv =====
module tb_polarisation_match_max;
  import pmm_pkg::*;

  // The samples use the block's default width. They are brought to Q4.28
  // before any arithmetic, so the predictor handles other widths as well.
  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int UP_SHIFT = (SW < 32) ? 32 - SW : 0;
  localparam int DN_SHIFT = (SW > 32) ? SW - 32 : 0;

  // Lags to send in all, the directed part included.
  localparam int LAG_COUNT = 900;
  // This many quiet cycles at the end catch any result that should not appear.
  localparam int DRAIN_CYCLES = 600;
  // The limit allows several times the slowest correct run: about 900 lags,
  // each followed by the longest sender gap and the longest receiver stall.
  localparam int CYCLE_LIMIT = 12000000;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_ONE = 1;
  localparam logic signed [SW-1:0] S_NEG_ONE = -1;
  localparam logic signed [SW-1:0] S_ZERO = 0;

  // One lag as the input channel carries it.
  typedef struct {
    logic signed [SW-1:0] pp;
    logic signed [SW-1:0] pc;
    logic signed [SW-1:0] cp;
    logic signed [SW-1:0] cc;
    logic                 last_lag;
  } lag_t;

  // The three halved maxima that close one series of lags.
  typedef struct {
    logic [31:0] typical;
    logic [31:0] best;
    logic [31:0] minimax;
  } match_set_t;

  // The tracker mirrors the block: it keeps the running maxima of the three
  // matches and queues the halved maxima that each last lag produces.
  class match_tracker;
    logic [33:0] peak_typical;
    logic [33:0] peak_best;
    logic [33:0] peak_minimax;
    match_set_t  pending[$];
    int          error_count;

    function new();
      peak_typical = '0;
      peak_best    = '0;
      peak_minimax = '0;
      error_count  = 0;
    endfunction

    function logic signed [63:0] to_q28(logic signed [SW-1:0] raw);
      logic signed [63:0] v;
      v = raw;
      v = v <<< UP_SHIFT;
      v = v >>> DN_SHIFT;
      return v;
    endfunction

    function logic [63:0] magnitude(logic signed [63:0] v);
      return (v < 0) ? -v : v;
    endfunction

    function logic [63:0] floor_root(logic [127:0] n);
      logic [63:0]  r;
      logic [127:0] t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        t = {64'b0, r | (64'b1 << b)};
        if (t * t <= n) r = t[63:0];
      end
      return r;
    endfunction

    // Twice the root in Q5.29 is the half match in Q1.31, clipped at all ones.
    function logic [31:0] half_match(logic [33:0] root);
      logic [34:0] twice;
      twice = {root, 1'b0};
      return (twice > 35'h0FFFFFFFF) ? 32'hFFFFFFFF : twice[31:0];
    endfunction

    function void take_lag(lag_t lag);
      logic signed [63:0] pp, pc, cp, cc, p1, p2;
      logic signed [65:0] csum, cabs;
      logic [63:0]        a, b, diff, cmag, s, rt_t, rt_b, rt_m;
      logic [127:0]       wd, wc, inner, sum2, s4;
      match_set_t         res;
      pp = to_q28(lag.pp);
      pc = to_q28(lag.pc);
      cp = to_q28(lag.cp);
      cc = to_q28(lag.cc);
      a = magnitude(pp) * magnitude(pp) + magnitude(pc) * magnitude(pc);
      b = magnitude(cp) * magnitude(cp) + magnitude(cc) * magnitude(cc);
      p1 = pp * cp;
      p2 = pc * cc;
      csum = p1 + p2;
      cabs = (csum < 0) ? -csum : csum;
      cmag = cabs[63:0];
      diff = (a > b) ? a - b : b - a;
      wd = {64'b0, diff};
      wc = {64'b0, cmag};
      inner = ((wd * wd) >> 2) + wc * wc;
      s = floor_root(inner);
      sum2 = ({64'b0, a} + {64'b0, b}) << 1;
      s4 = {64'b0, s} << 2;
      rt_t = floor_root({64'b0, a} << 2);
      rt_b = floor_root(sum2 + s4);
      // A minimax radicand below zero is taken as zero.
      rt_m = floor_root((sum2 > s4) ? sum2 - s4 : 128'b0);
      if (rt_t > {30'b0, peak_typical}) peak_typical = rt_t[33:0];
      if (rt_b > {30'b0, peak_best}) peak_best = rt_b[33:0];
      if (rt_m > {30'b0, peak_minimax}) peak_minimax = rt_m[33:0];
      if (lag.last_lag) begin
        res.typical = half_match(peak_typical);
        res.best    = half_match(peak_best);
        res.minimax = half_match(peak_minimax);
        pending.push_back(res);
        peak_typical = '0;
        peak_best    = '0;
        peak_minimax = '0;
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
    endtask

    task check_match(match_set_t got);
      match_set_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result %h %h %h with none expected",
                                  got.typical, got.best, got.minimax));
        return;
      end
      want = pending.pop_front();
      if (got.typical !== want.typical)
        report_mismatch($sformatf("typical_match %h, expected %h", got.typical, want.typical));
      if (got.best !== want.best)
        report_mismatch($sformatf("best_match %h, expected %h", got.best, want.best));
      if (got.minimax !== want.minimax)
        report_mismatch($sformatf("minimax_match %h, expected %h", got.minimax, want.minimax));
    endtask
  endclass

  logic clk;
  logic rst_n;

  pmm_in_if #(.SAMPLE_WIDTH(SW)) lag_ch();
  pmm_out_if                     match_ch();

  polarisation_match_max #(.SAMPLE_WIDTH(SW)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (lag_ch),
    .out_ch (match_ch)
  );

  match_tracker tracker;
  int           lags_sent;
  int           cycle_count;
  // While this is set neither side idles, so lags follow each other as
  // fast as the block takes them.
  logic         calm_stretch;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // A sample of one of several kinds: the two extremes, small values of
  // either sign, medium values from a random arithmetic shift, or raw bits.
  function automatic logic signed [SW-1:0] pick_sample();
    logic [63:0]          raw;
    logic signed [SW-1:0] v;
    int                   kind;
    raw = {$urandom, $urandom};
    kind = $urandom_range(9);
    v = raw[SW-1:0];
    case (kind)
      0: v = S_MAX;
      1: v = S_MIN;
      2: begin
        v = $urandom_range(255);
        if ($urandom_range(1)) v = -v;
      end
      3, 4: v = v >>> $urandom_range(1, SW - 2);
      default: ;
    endcase
    return v;
  endfunction

  function automatic lag_t lag_of(logic signed [SW-1:0] pp, logic signed [SW-1:0] pc,
                                  logic signed [SW-1:0] cp, logic signed [SW-1:0] cc,
                                  logic last_lag);
    lag_t lag;
    lag.pp = pp;
    lag.pc = pc;
    lag.cp = cp;
    lag.cc = cc;
    lag.last_lag = last_lag;
    return lag;
  endfunction

  // Offer one lag and hold it until the block takes it. The transfer happens
  // at the edge where valid and ready are both high; ready is sampled just
  // after the edge, before the block updates it. Valid stays high into the
  // next lag unless a gap is drawn, so it is never lowered and raised again
  // in one time step.
  task automatic send_lag(lag_t lag);
    int gap;
    lag_ch.valid    <= 1'b1;
    lag_ch.corr_pp  <= lag.pp;
    lag_ch.corr_pc  <= lag.pc;
    lag_ch.corr_cp  <= lag.cp;
    lag_ch.corr_cc  <= lag.cc;
    lag_ch.last_lag <= lag.last_lag;
    do @(posedge clk); while (!lag_ch.ready);
    tracker.take_lag(lag);
    lags_sent++;
    if (!calm_stretch && $urandom_range(99) < 24) begin
      // Mostly short gaps, some longer than a whole lag so that the next
      // lag turns up at any phase of the block's work.
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 700) : $urandom_range(1, 30);
      lag_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Main sequence: reset, directed lags, random series, drain, verdict.
  initial begin
    lag_t lag;
    int   series_len;
    int   shape;
    tracker = new();
    lags_sent = 0;
    calm_stretch = 1'b0;
    rst_n           <= 1'b0;
    lag_ch.valid    <= 1'b0;
    lag_ch.corr_pp  <= '0;
    lag_ch.corr_pc  <= '0;
    lag_ch.corr_cp  <= '0;
    lag_ch.corr_cc  <= '0;
    lag_ch.last_lag <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-lag series at the corners of the sample range. All-maximum and
    // all-minimum samples push the typical and best matches into saturation.
    send_lag(lag_of(S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b1));
    send_lag(lag_of(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1));
    send_lag(lag_of(S_MIN, S_MIN, S_MIN, S_MIN, 1'b1));
    send_lag(lag_of(S_MAX, S_MIN, S_MIN, S_MAX, 1'b1));
    send_lag(lag_of(S_ONE, S_NEG_ONE, S_ONE, S_NEG_ONE, 1'b1));
    // Parallel and antiparallel templates: the minimax radicand is exactly
    // zero, which is where a negative value from rounding would be clamped.
    send_lag(lag_of(SW'(32'sh01234567), SW'(-32'sh00ABCDEF),
                    SW'(32'sh01234567), SW'(-32'sh00ABCDEF), 1'b1));
    send_lag(lag_of(SW'(32'sh10000000), SW'(32'sh02000000),
                    SW'(-32'sh10000000), SW'(-32'sh02000000), 1'b1));
    // Orthogonal templates make C vanish.
    send_lag(lag_of(SW'(32'sh0F000000), SW'(32'sh03000000),
                    SW'(-32'sh03000000), SW'(32'sh0F000000), 1'b1));
    // A series whose largest lag comes first; later lags must not lower it.
    send_lag(lag_of(SW'(32'sh20000000), SW'(32'sh01000000),
                    SW'(32'sh00100000), SW'(-32'sh18000000), 1'b0));
    send_lag(lag_of(SW'(32'sh00010000), S_ZERO, SW'(32'sh00020000), S_ZERO, 1'b0));
    send_lag(lag_of(S_NEG_ONE, S_ONE, S_ZERO, S_NEG_ONE, 1'b0));
    send_lag(lag_of(SW'(32'sh00001000), SW'(32'sh00002000), S_ZERO, S_ZERO, 1'b1));
    // A series whose largest lag is the last one.
    send_lag(lag_of(S_ONE, S_ZERO, S_ZERO, S_ONE, 1'b0));
    send_lag(lag_of(SW'(32'sh00400000), SW'(-32'sh00400000), S_ONE, S_ONE, 1'b0));
    send_lag(lag_of(SW'(-32'sh3FFFFFFF), SW'(32'sh12345678),
                    SW'(32'sh07654321), SW'(-32'sh2AAAAAAA), 1'b1));
    // pp, cc and pc each alone at an extreme, pp and cp together, and B alone.
    send_lag(lag_of(S_MAX, S_ZERO, S_ZERO, S_ZERO, 1'b1));
    send_lag(lag_of(S_ZERO, S_ZERO, S_ZERO, S_MIN, 1'b1));
    send_lag(lag_of(S_MAX, S_ZERO, S_MIN, S_ZERO, 1'b1));
    send_lag(lag_of(S_ZERO, S_ZERO, S_MAX, S_MAX, 1'b1));
    send_lag(lag_of(S_ZERO, S_MIN, S_ZERO, S_ZERO, 1'b1));

    // Random series, mostly short. One stretch of lags runs with no idling
    // on either side.
    while (lags_sent < LAG_COUNT) begin
      series_len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      for (int k = 0; k < series_len; k++) begin
        calm_stretch = (lags_sent >= 350) && (lags_sent < 520);
        lag.pp = pick_sample();
        lag.pc = pick_sample();
        lag.cp = pick_sample();
        lag.cc = pick_sample();
        lag.last_lag = (k == series_len - 1);
        shape = $urandom_range(19);
        if (shape < 3) begin
          lag.cp = lag.pp;
          lag.cc = lag.pc;
        end else if (shape < 5) begin
          lag.cp = -lag.pp;
          lag.cc = -lag.pc;
        end else if (shape < 7) begin
          lag.cp = -lag.pc;
          lag.cc = lag.pp;
        end
        send_lag(lag);
      end
    end
    calm_stretch = 1'b0;
    lag_ch.valid <= 1'b0;

    // Wait for every queued result, then watch a while for strays. The
    // watchdog below bounds both waits.
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side. Each edge the transfer is checked against the oldest
  // expectation, then ready is drawn for the next cycle: about one cycle in
  // four stalled, and now and then a stall longer than a lag, so that a
  // second last lag must wait for the output register to drain.
  initial begin
    int         stall_left;
    match_set_t got;
    stall_left = 0;
    match_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (match_ch.valid && match_ch.ready) begin
        got.typical = match_ch.typical_match;
        got.best    = match_ch.best_match;
        got.minimax = match_ch.minimax_match;
        tracker.check_match(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        match_ch.ready <= 1'b0;
      end else if (!calm_stretch && $urandom_range(2999) == 0) begin
        stall_left = $urandom_range(1, 1500);
        match_ch.ready <= 1'b0;
      end else begin
        match_ch.ready <= calm_stretch || ($urandom_range(99) >= 24);
      end
    end
  end

  // Watchdog: a run that reaches the cycle limit has hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
